### rtl/mdct_pkg.sv
// Shared types, codes and constant tables of the MIDI drum channel tracker.
package mdct_pkg;

  // Channel count and index width
  localparam int CHANNELS = 16;
  localparam int CHW      = 4;

  // Command queue depth and pointer width
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // Synth modes
  localparam logic [1:0] MODE_GM    = 2'd0;
  localparam logic [1:0] MODE_GM_L2 = 2'd1;
  localparam logic [1:0] MODE_GS    = 2'd2;
  localparam logic [1:0] MODE_XG    = 2'd3;

  // Command codes passed from the front to the back
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_PROG   = 3'd1;
  localparam logic [2:0] OP_BANK   = 3'd2;
  localparam logic [2:0] OP_RESET  = 3'd3;
  localparam logic [2:0] OP_GS_MAP = 3'd4;
  localparam logic [2:0] OP_GS_RHY = 3'd5;

  // Short message commands (high nibble of status)
  localparam logic [3:0] CMD_CTRL = 4'hB;
  localparam logic [3:0] CMD_PROG = 4'hC;

  // Bank select values
  localparam logic [6:0] BANK_XG_DRUM  = 7'd127;
  localparam logic [6:0] BANK_GM2_DRUM = 7'd120;
  localparam logic [6:0] BANK_GM2_MEL  = 7'd121;

  // Default drum channel
  localparam logic [CHW-1:0] DRUM_CH = 4'd9;

  // System-exclusive patterns
  localparam logic [7:0] PAT_GM  [0:5] = '{8'hF0, 8'h7E, 8'h7F, 8'h09, 8'h01, 8'hF7};
  localparam logic [7:0] PAT_GM2 [0:5] = '{8'hF0, 8'h7E, 8'h7F, 8'h09, 8'h03, 8'hF7};
  localparam logic [7:0] PAT_GS  [0:10] = '{8'hF0, 8'h41, 8'h10, 8'h42, 8'h12, 8'h40,
                                            8'h00, 8'h7F, 8'h00, 8'h41, 8'hF7};
  localparam logic [7:0] PAT_XG  [0:8] = '{8'hF0, 8'h43, 8'h10, 8'h4C, 8'h00, 8'h00,
                                           8'h7E, 8'h00, 8'hF7};

  // GS part message addresses
  localparam logic [7:0] GS_ADDR_MAP = 8'h02;
  localparam logic [7:0] GS_ADDR_RHY = 8'h15;

  // One queued command
  typedef struct packed {
    logic [2:0]     op;
    logic [CHW-1:0] chan;
    logic [6:0]     val;
    logic [1:0]     mode;
  } cmd_t;

  // Default part-to-channel map: 9,0,1,...,8,10,...,15
  function automatic logic [6:0] default_map(input logic [CHW-1:0] idx);
    logic [6:0] r;
    if (idx == '0) begin
      r = {3'b0, DRUM_CH};
    end else if (idx <= DRUM_CH) begin
      r = {3'b0, idx - 4'd1};
    end else begin
      r = {3'b0, idx};
    end
    return r;
  endfunction

endpackage

### rtl/midi_drum_channel_tracker_core.sv
// Top level of the MIDI drum channel tracker: front, command queue and back.
//
//  channel | dir | tdata (low bit up)                                   | tuser    | tlast
//  in_     | in  | status[7:0] data_first[14:8] data_second[21:15]      | req_type | sysex_end
//          |     | sysex_byte[29:22], zero fill                         |          |
//  out_    | out | channel[3:0] drum_enable[4], zero fill               | -        | last
//
// A short message or sysex byte is taken while in_tready is high; after the final sysex
// byte the front holds off input while it judges the gathered message, until the queue has room.
// The back carries out one queued command a cycle while its output is free; a reset pushes 16
// results, one per cycle while out_tready is high, and takes no other command meanwhile.
// The front stalls when the four-entry command queue is full.
// rst_n (synchronous) restores GM mode, default drum flags and part map; no clearing pass.
module midi_drum_channel_tracker_core #(
  parameter int SYSEX_KEEP = 11
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // status, data_first, data_second, sysex_byte
  input  logic        in_tuser,   // req_type
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // channel, drum_enable
  output logic        out_tlast
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  mdct_pkg::cmd_t push_cmd;
  mdct_pkg::cmd_t head_cmd;

  mdct_front #(
    .SYSEX_KEEP(SYSEX_KEEP)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  mdct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  mdct_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

### rtl/mdct_front.sv
// Front part: accepts input items, gathers sysex bytes and classifies them into commands.
module mdct_front #(
  parameter int SYSEX_KEEP = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               in_tlast,
  input  logic               q_full,
  output logic               q_push,
  output mdct_pkg::cmd_t     q_cmd
);

  localparam int CW = $clog2(SYSEX_KEEP + 2);
  localparam int AW = $clog2(SYSEX_KEEP);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_JUDGE = 1'b1;

  logic          state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    sysex_buf_r [SYSEX_KEEP];

  logic          accept;
  logic [7:0]    status;
  logic [6:0]    data_first;
  logic [6:0]    data_second;
  logic [7:0]    sysex_byte;
  logic          gm_ok, gm2_ok, gs_ok, xg_ok, part_ok;
  logic [8:0]    gs_sum;
  mdct_pkg::cmd_t judge_cmd;
  mdct_pkg::cmd_t short_cmd;

  assign status      = in_tdata[7:0];
  assign data_first  = in_tdata[14:8];
  assign data_second = in_tdata[21:15];
  assign sysex_byte  = in_tdata[29:22];

  assign in_tready = (state_r == ST_IDLE) && !q_full;
  assign accept    = in_tvalid && in_tready;

  // Classify a short channel message
  always_comb begin
    short_cmd      = '0;
    short_cmd.op   = mdct_pkg::OP_NONE;
    short_cmd.chan = status[3:0];
    short_cmd.val  = data_second;
    if (status[7:4] == mdct_pkg::CMD_CTRL && data_first == 7'd0) begin
      short_cmd.op = mdct_pkg::OP_BANK;
    end else if (status[7:4] == mdct_pkg::CMD_PROG) begin
      short_cmd.op = mdct_pkg::OP_PROG;
    end
  end

  // Match the gathered sysex message against the known patterns
  always_comb begin
    gm_ok  = (count_r == CW'(6));
    gm2_ok = (count_r == CW'(6));
    for (int i = 0; i < 6; i++) begin
      gm_ok  = gm_ok  && (sysex_buf_r[i] == mdct_pkg::PAT_GM[i]);
      gm2_ok = gm2_ok && (sysex_buf_r[i] == mdct_pkg::PAT_GM2[i]);
    end
    xg_ok = (count_r == CW'(9));
    for (int i = 0; i < 9; i++) begin
      xg_ok = xg_ok && (sysex_buf_r[i] == mdct_pkg::PAT_XG[i]);
    end
    gs_sum = {1'b0, sysex_buf_r[5]} + {1'b0, sysex_buf_r[6]} + 9'd1;
    gs_ok  = (count_r == CW'(11));
    for (int i = 0; i < 5; i++) begin
      gs_ok = gs_ok && (sysex_buf_r[i] == mdct_pkg::PAT_GS[i]);
    end
    gs_ok = gs_ok && (sysex_buf_r[7] == mdct_pkg::PAT_GS[7])
                  && (sysex_buf_r[8] == mdct_pkg::PAT_GS[8])
                  && ({1'b0, gs_sum[6:0]} == sysex_buf_r[9])
                  && (sysex_buf_r[10] == mdct_pkg::PAT_GS[10]);
    part_ok = (count_r == CW'(11))
           && (sysex_buf_r[0] == mdct_pkg::PAT_GS[0])
           && (sysex_buf_r[1] == mdct_pkg::PAT_GS[1])
           && (sysex_buf_r[3] == mdct_pkg::PAT_GS[3])
           && (sysex_buf_r[4] == mdct_pkg::PAT_GS[4])
           && (sysex_buf_r[5] == mdct_pkg::PAT_GS[5])
           && (sysex_buf_r[6][7:4] == 4'h1)
           && (sysex_buf_r[10] == mdct_pkg::PAT_GS[10]);

    judge_cmd      = '0;
    judge_cmd.op   = mdct_pkg::OP_NONE;
    judge_cmd.chan = sysex_buf_r[6][3:0];
    judge_cmd.val  = sysex_buf_r[8][6:0];
    if (gm_ok) begin
      judge_cmd.op   = mdct_pkg::OP_RESET;
      judge_cmd.mode = mdct_pkg::MODE_GM;
    end else if (gm2_ok) begin
      judge_cmd.op   = mdct_pkg::OP_RESET;
      judge_cmd.mode = mdct_pkg::MODE_GM_L2;
    end else if (gs_ok) begin
      judge_cmd.op   = mdct_pkg::OP_RESET;
      judge_cmd.mode = mdct_pkg::MODE_GS;
    end else if (xg_ok) begin
      judge_cmd.op   = mdct_pkg::OP_RESET;
      judge_cmd.mode = mdct_pkg::MODE_XG;
    end else if (part_ok && sysex_buf_r[7] == mdct_pkg::GS_ADDR_MAP) begin
      judge_cmd.op = mdct_pkg::OP_GS_MAP;
    end else if (part_ok && sysex_buf_r[7] == mdct_pkg::GS_ADDR_RHY) begin
      judge_cmd.op  = mdct_pkg::OP_GS_RHY;
      judge_cmd.val = {6'b0, (sysex_buf_r[8] != 8'd0)};
    end
  end

  // Sequence accepts and judging
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    q_push    = 1'b0;
    q_cmd     = short_cmd;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!in_tuser) begin
            q_push = (short_cmd.op != mdct_pkg::OP_NONE);
          end else begin
            if (count_r < CW'(SYSEX_KEEP)) begin
              count_nxt = count_r + CW'(1);
            end else begin
              count_nxt = CW'(SYSEX_KEEP + 1);
            end
            if (in_tlast) begin
              state_nxt = ST_JUDGE;
            end
          end
        end
      end
      ST_JUDGE: begin
        q_cmd = judge_cmd;
        if (!q_full) begin
          q_push    = (judge_cmd.op != mdct_pkg::OP_NONE);
          count_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Store the sysex byte while room is left
  always_ff @(posedge clk) begin
    if (accept && in_tuser && count_r < CW'(SYSEX_KEEP)) begin
      sysex_buf_r[count_r[AW-1:0]] <= sysex_byte;
    end
  end

  // Hold off new items while a message is judged
  a_judge_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_JUDGE |-> !in_tready)
    else $error("front accepted an item while judging");

  // A final sysex byte always leads to judging
  a_end_judges: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser && in_tlast |=> state_r == ST_JUDGE && !in_tready)
    else $error("final sysex byte not judged");

endmodule

### rtl/mdct_queue.sv
// Command queue between the front and the back.
module mdct_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mdct_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mdct_pkg::cmd_t head_cmd
);

  mdct_pkg::cmd_t                entry_r [mdct_pkg::QDEPTH];
  logic [mdct_pkg::QAW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [mdct_pkg::QAW:0]        count_r;

  assign full      = (count_r == (mdct_pkg::QAW+1)'(mdct_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head_cmd  = entry_r[rd_ptr_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Never write a full queue unless it pops in the same cycle, nor read an empty one
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full || pop)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue underflow");

endmodule

### rtl/mdct_back.sv
// Back part: holds mode, drum flags and part map, carries out commands and drives pushes.
module mdct_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  mdct_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PUSH = 1'b1;

  logic                     state_r;
  logic [mdct_pkg::CHW-1:0] idx_r;
  logic [1:0]               mode_r;
  logic                     flags_r [mdct_pkg::CHANNELS];
  logic [6:0]               map_r   [mdct_pkg::CHANNELS];

  logic                     out_valid_r;
  logic [mdct_pkg::CHW-1:0] out_chan_r;
  logic                     out_drum_r;
  logic                     out_last_r;

  logic                     slot_free;
  logic                     do_push;
  logic [6:0]               rhy_ch;

  assign slot_free = !out_valid_r || out_tready;
  assign q_pop     = (state_r == ST_IDLE) && q_not_empty && slot_free;
  assign do_push   = (state_r == ST_PUSH) && slot_free;
  assign rhy_ch    = map_r[q_cmd.chan];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_drum_r, out_chan_r};
  assign out_tlast  = out_last_r;

  // Sequence commands and the reset sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_pop && q_cmd.op == mdct_pkg::OP_RESET) begin
            state_r <= ST_PUSH;
            idx_r   <= '0;
          end
        end
        ST_PUSH: begin
          if (do_push) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == mdct_pkg::CHW'(mdct_pkg::CHANNELS - 1)) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Update mode, drum flags and part map
  always_ff @(posedge clk) begin
    if (!rst_n || (q_pop && q_cmd.op == mdct_pkg::OP_RESET)) begin
      for (int i = 0; i < mdct_pkg::CHANNELS; i++) begin
        flags_r[i] <= (mdct_pkg::CHW'(i) == mdct_pkg::DRUM_CH);
        map_r[i]   <= mdct_pkg::default_map(mdct_pkg::CHW'(i));
      end
      mode_r <= !rst_n ? mdct_pkg::MODE_GM : q_cmd.mode;
    end else if (q_pop) begin
      case (q_cmd.op)
        mdct_pkg::OP_BANK: begin
          if (mode_r == mdct_pkg::MODE_XG) begin
            flags_r[q_cmd.chan] <= (q_cmd.val == mdct_pkg::BANK_XG_DRUM);
          end else if (mode_r == mdct_pkg::MODE_GM_L2) begin
            if (q_cmd.val == mdct_pkg::BANK_GM2_DRUM) begin
              flags_r[q_cmd.chan] <= 1'b1;
            end else if (q_cmd.val == mdct_pkg::BANK_GM2_MEL) begin
              flags_r[q_cmd.chan] <= 1'b0;
            end
          end
        end
        mdct_pkg::OP_GS_MAP: begin
          if (mode_r == mdct_pkg::MODE_GS) begin
            map_r[q_cmd.chan] <= q_cmd.val;
          end
        end
        mdct_pkg::OP_GS_RHY: begin
          // drop the write when the part maps to no channel
          if (mode_r == mdct_pkg::MODE_GS && rhy_ch < 7'(mdct_pkg::CHANNELS)) begin
            flags_r[rhy_ch[mdct_pkg::CHW-1:0]] <= q_cmd.val[0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Output register: program change push or reset sweep push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && q_cmd.op == mdct_pkg::OP_PROG) begin
      out_valid_r <= 1'b1;
    end else if (do_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_cmd.op == mdct_pkg::OP_PROG) begin
      out_chan_r <= q_cmd.chan;
      out_drum_r <= flags_r[q_cmd.chan];
      out_last_r <= 1'b1;
    end else if (do_push) begin
      out_chan_r <= idx_r;
      out_drum_r <= (idx_r == mdct_pkg::DRUM_CH);
      out_last_r <= (idx_r == mdct_pkg::CHW'(mdct_pkg::CHANNELS - 1));
    end
  end

  // No command is taken during the sweep
  a_sweep_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_PUSH |-> !q_pop)
    else $error("command popped during reset sweep");

  // A reset command starts the sweep at channel zero
  a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_cmd.op == mdct_pkg::OP_RESET |=> state_r == ST_PUSH && idx_r == '0)
    else $error("reset command did not start the sweep");

endmodule
